// ===== hdl/point_plane_signed_distance_macros.svh =====
// Assertion helpers for the point-plane distance RTL.
`ifndef POINT_PLANE_SIGNED_DISTANCE_MACROS_SVH
`define POINT_PLANE_SIGNED_DISTANCE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PPSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppsd: implication check failed");

// Condition that must never hold outside reset.
`define PPSD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("ppsd: forbidden condition seen");

`endif

// ===== hdl/ppsd_pkg.sv =====
// ---------------------------------------------------------------------------
// ppsd_pkg
// Item types and fixed widths for the point-plane signed distance pipeline.
// ---------------------------------------------------------------------------
package ppsd_pkg;

    localparam int SQ_W     = 70;   // |N|^2
    localparam int LEN_W    = 36;   // floor(sqrt(|N|^2))
    localparam int DOT_W    = 54;   // dot(N, D), signed
    localparam int Q_W      = 18;   // quotient bits before clamp
    localparam int DIST_W   = 18;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 18'sd131071;
    localparam logic signed [DIST_W-1:0] DIST_MIN = -18'sd131072;

    typedef struct packed {
        logic signed [15:0] corner_a_x;
        logic signed [15:0] corner_a_y;
        logic signed [15:0] corner_a_z;
        logic signed [15:0] corner_b_x;
        logic signed [15:0] corner_b_y;
        logic signed [15:0] corner_b_z;
        logic signed [15:0] corner_c_x;
        logic signed [15:0] corner_c_y;
        logic signed [15:0] corner_c_z;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     degenerate;
    } t_out_item;

    typedef struct packed {
        logic                    vld;
        logic [SQ_W-1:0]         sq;
        logic signed [DOT_W-1:0] dot;
    } t_geo_item;

    typedef struct packed {
        logic                    vld;
        logic [LEN_W-1:0]        len;
        logic signed [DOT_W-1:0] dot;
    } t_len_item;

endpackage

// ===== hdl/ppsd_front.sv =====
// ---------------------------------------------------------------------------
// ppsd_front
// Five stages: differences, cross products, normal, squares and dot terms,
// sums.
// ---------------------------------------------------------------------------
module ppsd_front
    import ppsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  t_in_item  i_item,
    output t_geo_item o_geo
);

    logic              r_vld [5];
    logic signed [16:0] r_u [3];
    logic signed [16:0] r_v [3];
    logic signed [16:0] r_d1 [3];
    logic signed [16:0] r_d2 [3];
    logic signed [16:0] r_d3 [3];
    logic signed [33:0] r_p [6];
    logic signed [34:0] r_n [3];
    logic [69:0]        r_sq [3];
    logic signed [51:0] r_t [3];
    logic [SQ_W-1:0]    r_sum;
    logic signed [DOT_W-1:0] r_dot;
    logic [34:0]        w_mag [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < 5; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // stage 1: edge vectors and point offset
    always_ff @(posedge i_clk) begin
        r_u[0] <= {i_item.corner_a_x[15], i_item.corner_a_x}
                - {i_item.corner_b_x[15], i_item.corner_b_x};
        r_u[1] <= {i_item.corner_a_y[15], i_item.corner_a_y}
                - {i_item.corner_b_y[15], i_item.corner_b_y};
        r_u[2] <= {i_item.corner_a_z[15], i_item.corner_a_z}
                - {i_item.corner_b_z[15], i_item.corner_b_z};
        r_v[0] <= {i_item.corner_a_x[15], i_item.corner_a_x}
                - {i_item.corner_c_x[15], i_item.corner_c_x};
        r_v[1] <= {i_item.corner_a_y[15], i_item.corner_a_y}
                - {i_item.corner_c_y[15], i_item.corner_c_y};
        r_v[2] <= {i_item.corner_a_z[15], i_item.corner_a_z}
                - {i_item.corner_c_z[15], i_item.corner_c_z};
        r_d1[0] <= {i_item.point_x[15], i_item.point_x}
                 - {i_item.corner_a_x[15], i_item.corner_a_x};
        r_d1[1] <= {i_item.point_y[15], i_item.point_y}
                 - {i_item.corner_a_y[15], i_item.corner_a_y};
        r_d1[2] <= {i_item.point_z[15], i_item.point_z}
                 - {i_item.corner_a_z[15], i_item.corner_a_z};
    end

    // stage 2: cross-product partial terms
    always_ff @(posedge i_clk) begin
        r_p[0] <= r_u[1] * r_v[2];
        r_p[1] <= r_u[2] * r_v[1];
        r_p[2] <= r_u[2] * r_v[0];
        r_p[3] <= r_u[0] * r_v[2];
        r_p[4] <= r_u[0] * r_v[1];
        r_p[5] <= r_u[1] * r_v[0];
        r_d2   <= r_d1;
    end

    // stage 3: normal vector
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_n[i] <= {r_p[2*i][33], r_p[2*i]} - {r_p[2*i+1][33], r_p[2*i+1]};
        end
        r_d3 <= r_d2;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_n[i][34] ? 35'(-r_n[i]) : 35'(r_n[i]);
        end
    end

    // stage 4: squares and dot terms
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= w_mag[i] * w_mag[i];
            r_t[i]  <= r_n[i] * r_d3[i];
        end
    end

    // stage 5: sums
    always_ff @(posedge i_clk) begin
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        r_dot <= {{2{r_t[0][51]}}, r_t[0]} + {{2{r_t[1][51]}}, r_t[1]}
               + {{2{r_t[2][51]}}, r_t[2]};
    end

    assign o_geo.vld = r_vld[4];
    assign o_geo.sq  = r_sum;
    assign o_geo.dot = r_dot;

endmodule

// ===== hdl/ppsd_sqrt.sv =====
// ---------------------------------------------------------------------------
// ppsd_sqrt
// Integer square root, one result bit per pipeline stage (36 stages).
// ---------------------------------------------------------------------------
module ppsd_sqrt
    import ppsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_geo_item i_geo,
    output t_len_item o_len
);

    logic                    r_vld  [LEN_W];
    logic [SQ_W-1:0]         r_rem  [LEN_W];
    logic [LEN_W-1:0]        r_root [LEN_W];
    logic signed [DOT_W-1:0] r_dot  [LEN_W];

    for (genvar g = 0; g < LEN_W; g++) begin : g_stage
        localparam int BIT = LEN_W - 1 - g;
        logic                    w_vld;
        logic [SQ_W-1:0]         w_rem;
        logic [LEN_W-1:0]        w_root;
        logic signed [DOT_W-1:0] w_dot;
        logic [2*LEN_W-1:0]      w_trial;
        logic [2*LEN_W-1:0]      w_rem_ext;

        if (g == 0) begin : g_first
            assign w_vld  = i_geo.vld;
            assign w_rem  = i_geo.sq;
            assign w_root = '0;
            assign w_dot  = i_geo.dot;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_dot  = r_dot[g-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign w_trial   = ({{LEN_W{1'b0}}, w_root} << (BIT + 1))
                         | ({{(2*LEN_W-1){1'b0}}, 1'b1} << (2 * BIT));
        assign w_rem_ext = {{(2*LEN_W-SQ_W){1'b0}}, w_rem};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dot[g] <= w_dot;
            if (w_rem_ext >= w_trial) begin
                r_rem[g]  <= SQ_W'(w_rem_ext - w_trial);
                r_root[g] <= w_root | (LEN_W'(1) << BIT);
            end else begin
                r_rem[g]  <= w_rem;
                r_root[g] <= w_root;
            end
        end
    end

    assign o_len.vld = r_vld[LEN_W-1];
    assign o_len.len = r_root[LEN_W-1];
    assign o_len.dot = r_dot[LEN_W-1];

endmodule

// ===== hdl/ppsd_div.sv =====
// ---------------------------------------------------------------------------
// ppsd_div
// Range check, 18-stage restoring divide of |dot| by length, then sign
// and clamp.
// ---------------------------------------------------------------------------
module ppsd_div
    import ppsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_len_item i_len,
    output logic      o_valid,
    output logic      o_neg,
    output t_out_item o_result
);

    localparam int MAG_W = DOT_W;

    logic               r_vld0;
    logic [MAG_W-1:0]   r_mag0;
    logic [LEN_W-1:0]   r_len0;
    logic               r_neg0, r_deg0, r_ovf0;

    logic               r_vld [Q_W];
    logic [MAG_W-1:0]   r_rem [Q_W];
    logic [Q_W-1:0]     r_q   [Q_W];
    logic [LEN_W-1:0]   r_ln  [Q_W];
    logic               r_ng  [Q_W];
    logic               r_dg  [Q_W];
    logic               r_ov  [Q_W];

    logic               r_out_vld;
    logic               r_out_neg;
    t_out_item          r_out;

    logic [MAG_W-1:0]   w_mag;
    logic [MAG_W-1:0]   w_lim;
    t_out_item          w_res;

    assign w_mag = i_len.dot[DOT_W-1] ? MAG_W'(-i_len.dot) : MAG_W'(i_len.dot);
    assign w_lim = {i_len.len, {Q_W{1'b0}}};

    // stage 0: magnitude, degenerate and overflow flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= i_len.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag0 <= w_mag;
        r_len0 <= i_len.len;
        r_neg0 <= i_len.dot[DOT_W-1];
        r_deg0 <= (i_len.len == '0);
        r_ovf0 <= (w_mag >= w_lim);
    end

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        localparam int BIT = Q_W - 1 - g;
        logic             w_vld, w_ng, w_dg, w_ov;
        logic [MAG_W-1:0] w_rem;
        logic [Q_W-1:0]   w_q;
        logic [LEN_W-1:0] w_ln;
        logic [MAG_W-1:0] w_trial;

        if (g == 0) begin : g_first
            assign w_vld = r_vld0;
            assign w_rem = r_mag0;
            assign w_q   = '0;
            assign w_ln  = r_len0;
            assign w_ng  = r_neg0;
            assign w_dg  = r_deg0;
            assign w_ov  = r_ovf0;
        end else begin : g_next
            assign w_vld = r_vld[g-1];
            assign w_rem = r_rem[g-1];
            assign w_q   = r_q[g-1];
            assign w_ln  = r_ln[g-1];
            assign w_ng  = r_ng[g-1];
            assign w_dg  = r_dg[g-1];
            assign w_ov  = r_ov[g-1];
        end

        assign w_trial = {{(MAG_W-LEN_W){1'b0}}, w_ln} << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ln[g] <= w_ln;
            r_ng[g] <= w_ng;
            r_dg[g] <= w_dg;
            r_ov[g] <= w_ov;
            if (w_rem >= w_trial) begin
                r_rem[g] <= w_rem - w_trial;
                r_q[g]   <= w_q | (Q_W'(1) << BIT);
            end else begin
                r_rem[g] <= w_rem;
                r_q[g]   <= w_q;
            end
        end
    end

    // apply sign and clamp
    always_comb begin
        w_res.degenerate = r_dg[Q_W-1];
        if (r_dg[Q_W-1]) begin
            w_res.distance = '0;
        end else if (r_ng[Q_W-1]) begin
            if (r_ov[Q_W-1] || (r_q[Q_W-1] > Q_W'(131072))) begin
                w_res.distance = DIST_MIN;
            end else begin
                w_res.distance = DIST_W'(-r_q[Q_W-1]);
            end
        end else begin
            if (r_ov[Q_W-1] || (r_q[Q_W-1] > Q_W'(131071))) begin
                w_res.distance = DIST_MAX;
            end else begin
                w_res.distance = DIST_W'(r_q[Q_W-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= w_res;
        r_out_neg <= r_ng[Q_W-1] && !r_dg[Q_W-1];
    end

    assign o_valid  = r_out_vld;
    assign o_neg    = r_out_neg;
    assign o_result = r_out;

endmodule

// ===== hdl/point_plane_signed_distance.sv =====
// ---------------------------------------------------------------------------
// point_plane_signed_distance
// Signed distance of a point from the plane through three corners.
// ---------------------------------------------------------------------------
// Fully pipelined: one item is taken on every clock where start is high, and
// busy never rises. Each result appears on o_result with o_valid high for
// exactly one cycle, in input order; the receiver cannot hold results off.
// From input to result: 5 stages form N = (A-B)x(A-C), |N|^2 and dot(N, P-A),
// 36 stages resolve one bit each of the integer square root, 1 stage checks
// the quotient range and 18 stages resolve one bit each of the quotient, and
// 1 stage applies sign, clamp and the degenerate case. A collinear or
// coincident corner set gives distance 0 with the degenerate flag set.
// ---------------------------------------------------------------------------
`include "point_plane_signed_distance_macros.svh"

module point_plane_signed_distance
    import ppsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    t_geo_item w_geo;
    t_len_item w_len;
    logic      w_neg;

    // the pipeline never stalls, so every start is taken
    assign busy = 1'b0;

    // geometry: edges, normal, |N|^2 and dot product
    ppsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_item  (i_item),
        .o_geo   (w_geo)
    );

    // length of the normal
    ppsd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geo   (w_geo),
        .o_len   (w_len)
    );

    // quotient, sign and clamp
    ppsd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_len    (w_len),
        .o_valid  (o_valid),
        .o_neg    (w_neg),
        .o_result (o_result)
    );

    // a degenerate plane reports zero distance
    `PPSD_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_valid && o_result.degenerate, o_result.distance == '0)
    // a negative dot product never yields a positive distance
    `PPSD_ASSERT_IMP(a_neg_sign, i_clk, i_rst_n, o_valid && w_neg, o_result.distance[DIST_W-1] || (o_result.distance == '0))
    // a non-negative dot product never yields a negative distance
    `PPSD_ASSERT_IMP(a_pos_sign, i_clk, i_rst_n, o_valid && !w_neg && !o_result.degenerate, !o_result.distance[DIST_W-1])
    // the pipeline never pushes back on start
    `PPSD_ASSERT_NEVER(a_busy_low, i_clk, i_rst_n, busy)

endmodule

// ===== tb/sv/tb_point_plane_signed_distance.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_point_plane_signed_distance
// Self-checking bench for the point-plane signed distance pipeline.
// Drives directed and random corner/point items, predicts each distance with
// exact integer arithmetic, and compares results in order as they come out.
// ---------------------------------------------------------------------------
module tb_point_plane_signed_distance;
    import ppsd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_valid;
    t_out_item o_result;

    t_out_item pending_dist_q[$];
    int        mismatch_cnt = 0;
    int        result_cnt = 0;
    int        item_cnt = 0;
    int        degen_cnt = 0;
    int        sat_cnt = 0;
    int        cycle_cnt = 0;
    bit        gaps_on = 1'b1;

    always #5 i_clk = ~i_clk;

    point_plane_signed_distance DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Exact predictor: cross product, integer sqrt of |N|^2, truncating divide.
    function automatic t_out_item plane_distance(t_in_item it);
        t_out_item r;
        logic signed [16:0] ux, uy, uz, vx, vy, vz, dx, dy, dz;
        logic signed [35:0] nx, ny, nz;
        logic [71:0] sq, trial;
        logic [35:0] len;
        logic signed [55:0] dotp;
        logic [55:0] mag, q;
        ux = it.corner_a_x - it.corner_b_x;
        uy = it.corner_a_y - it.corner_b_y;
        uz = it.corner_a_z - it.corner_b_z;
        vx = it.corner_a_x - it.corner_c_x;
        vy = it.corner_a_y - it.corner_c_y;
        vz = it.corner_a_z - it.corner_c_z;
        dx = it.point_x - it.corner_a_x;
        dy = it.point_y - it.corner_a_y;
        dz = it.point_z - it.corner_a_z;
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        sq = 72'(nx) * 72'(nx) + 72'(ny) * 72'(ny) + 72'(nz) * 72'(nz);
        len = '0;
        for (int b = 35; b >= 0; b--) begin
            trial = {36'd0, len | (36'd1 << b)};
            if (trial * trial <= sq) len = len | (36'd1 << b);
        end
        r = '0;
        if (len == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        dotp = 56'(nx) * dx + 56'(ny) * dy + 56'(nz) * dz;
        mag = dotp < 0 ? -dotp : dotp;
        q = mag / {20'd0, len};
        if (dotp < 0) r.distance = (q > 56'd131072) ? DIST_MIN : DIST_W'(-q);
        else          r.distance = (q > 56'd131071) ? DIST_MAX : DIST_W'(q);
        return r;
    endfunction

    // Send one item: hold start until it is taken, then, if gaps are on, idle a random while.
    task automatic send_item(t_in_item it);
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_dist_q.push_back(plane_distance(it));
        item_cnt++;
        while (gaps_on && $urandom_range(99) < 34) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(9))
            0: begin
                // collinear corners: C = B
                it.corner_c_x = it.corner_b_x;
                it.corner_c_y = it.corner_b_y;
                it.corner_c_z = it.corner_b_z;
            end
            1: begin
                it.corner_a_x = rand_coord(); it.corner_b_x = rand_coord();
                it.corner_c_y = rand_coord(); it.point_z = rand_coord();
            end
            2: begin
                // small plane, far point: normal along z, distances stay below the clamp
                it.corner_b_x = it.corner_a_x + 16'sd1;
                it.corner_b_y = it.corner_a_y;
                it.corner_b_z = it.corner_a_z;
                it.corner_c_x = it.corner_a_x;
                it.corner_c_y = it.corner_a_y + 16'sd1;
                it.corner_c_z = it.corner_a_z;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic test_extremes();
        t_in_item it;
        // unit plane z = 0 at origin, point on each side and at the range ends
        it = '0;
        it.corner_b_x = 16'sd16384;
        it.corner_c_y = 16'sd16384;
        it.point_z = 16'sd16384;   send_item(it);
        it.point_z = -16'sd16384;  send_item(it);
        it.point_z = 16'sh7FFF;    send_item(it);
        it.point_z = 16'sh8000;    send_item(it);
        it.point_z = 16'sd0;       send_item(it);
        // all fields at the positive then negative end: degenerate
        send_item('1 ^ {12{16'h8000}});
        send_item({12{16'h8000}});
        // all-ones, all-zero
        send_item('1);
        send_item('0);
        // tiny plane far from point: large distances of both signs, below the clamp
        it = '0;
        it.corner_a_x = 16'sh8000; it.corner_a_y = 16'sh8000; it.corner_a_z = 16'sh8000;
        it.corner_b_x = 16'sh8001; it.corner_b_y = 16'sh8000; it.corner_b_z = 16'sh8000;
        it.corner_c_x = 16'sh8000; it.corner_c_y = 16'sh8001; it.corner_c_z = 16'sh8000;
        it.point_x = 16'sh7FFF; it.point_y = 16'sh7FFF; it.point_z = 16'sh7FFF;
        send_item(it);
        it.corner_c_y = 16'sh8000; it.corner_c_x = 16'sh8000; it.corner_b_x = 16'sh8000;
        it.corner_b_y = 16'sh8001;
        it.corner_c_x = 16'sh8001;
        send_item(it);
        // largest triangle
        it.corner_a_x = 16'sh8000; it.corner_a_y = 16'sh8000; it.corner_a_z = 16'sh8000;
        it.corner_b_x = 16'sh7FFF; it.corner_b_y = 16'sh8000; it.corner_b_z = 16'sh8000;
        it.corner_c_x = 16'sh8000; it.corner_c_y = 16'sh7FFF; it.corner_c_z = 16'sh7FFF;
        it.point_x = 16'sh7FFF; it.point_y = 16'sh8000; it.point_z = 16'sh7FFF;
        send_item(it);
        go_idle();
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            // hold a long stretch with no gaps in the middle
            gaps_on = !(k >= n / 3 && k < n / 3 + 200);
            send_item(rand_item());
        end
        gaps_on = 1'b1;
        go_idle();
    endtask

    // Compare each result against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_valid) begin
            result_cnt++;
            if (pending_dist_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected result %0d/%0b", o_result.distance,
                             o_result.degenerate);
            end else begin
                exp_r = pending_dist_q.pop_front();
                if (exp_r.degenerate) degen_cnt++;
                if (exp_r.distance == DIST_MAX || exp_r.distance == DIST_MIN) sat_cnt++;
                if (o_result !== exp_r) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: result %0d exp dist=%0d degen=%0b got dist=%0d degen=%0b",
                                 result_cnt, exp_r.distance, exp_r.degenerate,
                                 o_result.distance, o_result.degenerate);
                end
            end
        end
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(1150);
        while (pending_dist_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d items, %0d results, %0d degenerate planes, %0d clamped.",
                 item_cnt, result_cnt, degen_cnt, sat_cnt);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ppsd_pkg.sv
hdl/ppsd_front.sv
hdl/ppsd_sqrt.sv
hdl/ppsd_div.sv
hdl/point_plane_signed_distance.sv
tb/sv/tb_point_plane_signed_distance.sv
